// ----- rtl/core/ttmc_pkg.sv -----
package ttmc_pkg;

  localparam int MemCells = 1018;
  localparam int LineCols = 80;
  localparam int LineRows = 25;
  localparam int AddrW = 10;
  localparam int ColW = 8;
  localparam int RowW = 7;

  localparam logic [6:0] ChNul = 7'h00;
  localparam logic [6:0] ChStx = 7'h02;
  localparam logic [6:0] ChEtx = 7'h03;
  localparam logic [6:0] ChEot = 7'h04;
  localparam logic [6:0] ChEnq = 7'h05;
  localparam logic [6:0] ChAck = 7'h06;
  localparam logic [6:0] ChBs = 7'h08;
  localparam logic [6:0] ChLf = 7'h0a;
  localparam logic [6:0] ChFf = 7'h0c;
  localparam logic [6:0] ChCr = 7'h0d;
  localparam logic [6:0] ChDc1 = 7'h11;
  localparam logic [6:0] ChDc3 = 7'h13;
  localparam logic [6:0] ChDc4 = 7'h14;
  localparam logic [6:0] ChRs = 7'h1e;
  localparam logic [6:0] ChUs = 7'h1f;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindUser = 2'd1,
    KindRead = 2'd2,
    KindNop  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RplNone = 3'd0,
    RplAck  = 3'd1,
    RplEot  = 3'd2,
    RplEnq  = 3'd3,
    RplStx  = 3'd4
  } reply_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StDelScan,
    StDelRd,
    StDelWr,
    StLocRd,
    StLocStep,
    StPlcRd,
    StPlcStep,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [9:0] read_address;
  } in_t;

  typedef struct packed {
    logic [2:0] reply;
    logic       redisplay;
    logic       unexpected;
    logic [6:0] read_data;
    logic [9:0] cursor_index;
    logic [9:0] end_index;
  } out_t;

endpackage

// ----- rtl/core/ttmc_if.sv -----
interface ttmc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ttmc_mem.sv -----
module ttmc_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ttmc_pkg::AddrW-1:0] waddr_i,
  input  logic [6:0]               wdata_i,
  input  logic [ttmc_pkg::AddrW-1:0] raddr_i,
  output logic [6:0]               rdata_o
);
  import ttmc_pkg::*;

  logic [6:0] mem [MemCells];

  always_ff @(posedge clk_i) begin
    if (we_i && (32'(waddr_i) < MemCells)) begin
      mem[waddr_i] <= wdata_i;
    end
    if (32'(raddr_i) < MemCells) begin
      rdata_o <= mem[raddr_i];
    end else begin
      rdata_o <= '0;
    end
  end
endmodule

// ----- rtl/core/terminal_text_memory_controller.sv -----
// Terminal text memory controller.
// in_if carries one transaction per request: a host byte, a user line ready
// event or a read of a memory cell. out_if returns exactly one result per
// request, with the reply code, redisplay and unexpected flags, the read data
// and the cursor and end indexes after the request.
// Requests are handled one at a time; in_if is not ready while one is in
// flight or its result waits. Ordinary bytes, protocol bytes and reads go
// through StRead, which waits on the registered read of the character
// memory, to StOut. DC1 scans cells in StDelScan and then moves each cell
// with a read in StDelRd and a write in StDelWr. DC3 walks the cells before
// the cursor and then, if it is past the first line, again from index 0,
// with a read state and a step state per cell visited.
// Reset clears the cursor, end index and flags; the character memory holds
// whatever it held and is defined only where it was written.
// When the receiver stalls, the result is held in out_if and no new
// request is taken until it is accepted.
module terminal_text_memory_controller (
  input logic clk_i,
  input logic rst_ni,
  ttmc_if.sink   in_if,
  ttmc_if.source out_if
);
  import ttmc_pkg::*;

  state_e state_q, state_d;
  in_t req_q;
  logic [AddrW-1:0] cur_q, cur_d, end_q, end_d, p_q, p_d, q_q, q_d;
  logic [RowW-1:0] row_q, row_d, drow_q, drow_d;
  logic [ColW-1:0] col_q, col_d, dcol_q, dcol_d;
  logic in_text_q, in_text_d, pend_q, pend_d;
  out_t res_q, res_d;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [6:0] wdata, rdata;
  logic [6:0] b7;
  logic [RowW-1:0] nrow;
  logic [ColW-1:0] ncol;
  logic brk;

  ttmc_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.data = res_q;
  assign b7 = req_q.rx_byte[6:0];

  always_comb begin
    brk = 1'b0;
    nrow = row_q;
    ncol = col_q;
    if (rdata == ChCr) begin
      ncol = ColW'(1);
      if (32'(row_q) >= LineRows) begin
        brk = 1'b1;
      end else begin
        nrow = row_q + RowW'(1);
      end
    end else begin
      ncol = col_q + ColW'(1);
      if (32'(ncol) > LineCols) begin
        ncol = ColW'(1);
        if (32'(row_q) >= LineRows) begin
          brk = 1'b1;
        end else begin
          nrow = row_q + RowW'(1);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    priority case (state_q)
      StIdle: if (in_if.valid) state_d = StRead;
      StRead: begin
        state_d = StOut;
        if (req_q.kind == KindByte && in_text_q && req_q.rx_byte[7] == 1'b0) begin
          if (b7 == ChDc1) state_d = StDelScan;
          if (b7 == ChDc3) state_d = StLocRd;
        end
      end
      StDelScan: begin
        if (p_q >= end_q || rdata == ChCr) state_d = (p_q > cur_q) ? StDelRd : StOut;
      end
      StDelRd: state_d = (p_q < end_q) ? StDelWr : StOut;
      StDelWr: state_d = StDelRd;
      StLocRd: state_d = (p_q < cur_q) ? StLocStep : StOut;
      StLocStep: state_d = brk ? StOut : StLocRd;
      StPlcRd: state_d = (p_q < end_q) ? StPlcStep : StOut;
      StPlcStep: begin
        if (brk || (nrow == drow_q && ncol == dcol_q)) state_d = StOut;
        else state_d = StPlcRd;
      end
      StOut: if (out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StLocRd && !(p_q < cur_q) && row_q > RowW'(1)) state_d = StPlcRd;
    if (state_q == StLocStep && brk && row_q > RowW'(1)) state_d = StPlcRd;
  end

  always_comb begin
    cur_d = cur_q;
    end_d = end_q;
    p_d = p_q;
    q_d = q_q;
    row_d = row_q;
    col_d = col_q;
    drow_d = drow_q;
    dcol_d = dcol_q;
    in_text_d = in_text_q;
    pend_d = pend_q;
    res_d = res_q;
    we = 1'b0;
    waddr = cur_q;
    wdata = b7;
    raddr = p_q;
    unique case (state_q)
      StIdle: raddr = in_if.data.read_address;
      StRead: begin
        res_d = '0;
        raddr = cur_q;
        p_d = cur_q;
        row_d = RowW'(1);
        col_d = ColW'(1);
        if (req_q.kind == KindRead) begin
          res_d.read_data = rdata;
        end else if (req_q.kind == KindUser) begin
          pend_d = 1'b1;
          res_d.reply = RplEnq;
        end else if (req_q.kind == KindByte) begin
          if (req_q.rx_byte == 8'(ChAck)) begin
            if (pend_q) begin
              res_d.reply = RplStx;
              pend_d = 1'b0;
              cur_d = '0;
              res_d.redisplay = 1'b1;
            end else begin
              res_d.reply = RplEot;
            end
          end else if (req_q.rx_byte == 8'(ChEot)) begin
            in_text_d = 1'b0;
          end else if (req_q.rx_byte == 8'(ChEnq)) begin
            res_d.reply = RplAck;
          end else if (req_q.rx_byte == 8'(ChStx)) begin
            in_text_d = 1'b1;
          end else if (req_q.rx_byte == 8'(ChEtx)) begin
            in_text_d = 1'b0;
            res_d.reply = RplAck;
            res_d.redisplay = 1'b1;
            wdata = ChEtx;
            we = 32'(cur_q) < MemCells;
          end else if (in_text_q) begin
            if ((req_q.rx_byte >= 8'h20 && req_q.rx_byte <= 8'h7e) ||
                req_q.rx_byte == 8'(ChCr) || req_q.rx_byte == 8'(ChRs) ||
                req_q.rx_byte == 8'(ChUs)) begin
              we = 32'(cur_q) < MemCells;
            end else if (req_q.rx_byte == 8'(ChLf)) begin
              wdata = ChCr;
              we = 32'(cur_q) < MemCells;
            end else if (req_q.rx_byte == 8'(ChBs)) begin
              if (cur_q != '0) cur_d = cur_q - AddrW'(1);
            end else if (req_q.rx_byte == 8'(ChDc4)) begin
              cur_d = '0;
            end else if (req_q.rx_byte == 8'(ChFf)) begin
              cur_d = '0;
              end_d = '0;
            end else if (req_q.rx_byte == 8'(ChDc1)) begin
              p_d = cur_q;
            end else if (req_q.rx_byte == 8'(ChDc3)) begin
              p_d = '0;
              raddr = '0;
            end else if (req_q.rx_byte != 8'(ChNul)) begin
              res_d.unexpected = 1'b1;
            end
          end else begin
            res_d.unexpected = 1'b1;
          end
          if (we) begin
            cur_d = cur_q + AddrW'(1);
            if (end_q < cur_d) end_d = cur_d;
          end
        end
      end
      StDelScan: begin
        if (p_q >= end_q || rdata == ChCr) begin
          q_d = cur_q;
          raddr = p_q;
        end else begin
          p_d = p_q + AddrW'(1);
          raddr = p_d;
        end
      end
      StDelRd: begin
        raddr = p_q;
        if (!(p_q < end_q)) end_d = end_q - (p_q - q_q);
      end
      StDelWr: begin
        we = 1'b1;
        waddr = q_q;
        wdata = rdata;
        q_d = q_q + AddrW'(1);
        p_d = p_q + AddrW'(1);
        raddr = p_d;
      end
      StLocRd: begin
        raddr = p_q;
        if (!(p_q < cur_q) && row_q > RowW'(1)) begin
          drow_d = row_q - RowW'(1);
          dcol_d = col_q;
          row_d = RowW'(1);
          col_d = ColW'(1);
          p_d = '0;
          raddr = '0;
        end
      end
      StLocStep: begin
        row_d = nrow;
        col_d = ncol;
        p_d = p_q + AddrW'(1);
        raddr = p_d;
        if (brk && row_q > RowW'(1)) begin
          drow_d = row_q - RowW'(1);
          dcol_d = ncol;
          row_d = RowW'(1);
          col_d = ColW'(1);
          p_d = '0;
          raddr = '0;
        end
      end
      StPlcRd: begin
        raddr = p_q;
        if (!(p_q < end_q)) cur_d = p_q;
      end
      StPlcStep: begin
        row_d = nrow;
        col_d = ncol;
        if (brk || (nrow == drow_q && ncol == dcol_q)) begin
          cur_d = p_q;
        end else begin
          p_d = p_q + AddrW'(1);
          raddr = p_d;
        end
      end
      StOut: ;
      default: ;
    endcase
    if (state_d == StOut && state_q != StOut) begin
      res_d.cursor_index = cur_d;
      res_d.end_index = end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_q <= '0;
      end_q <= '0;
      in_text_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      end_q <= end_d;
      in_text_q <= in_text_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_if.valid) req_q <= in_if.data;
    p_q <= p_d;
    q_q <= q_d;
    row_q <= row_d;
    col_q <= col_d;
    drow_q <= drow_d;
    dcol_q <= dcol_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");
  a_end_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(end_q) <= MemCells && 32'(cur_q) <= MemCells) else $error("index out of range");
`endif
endmodule
